// ===== sv/mtac_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor throttle arming controller package
// Shared types, command codes, register indexes and the speed check.
// ----------------------------------------------------------------------------
`default_nettype none

package mtac_pkg;

    // Field widths.
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned DELTA_W = 9;
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned IDX_W   = 3;
    // Wide enough for current speed plus or minus any 9-bit value, signed.
    localparam int unsigned SUM_W   = 11;

    // Stream payload widths, rounded up to whole bytes.
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    // Register reset values.
    localparam logic [SPEED_W-1:0] ARM_RST  = 8'd30;
    localparam logic [SPEED_W-1:0] MIN_RST  = 8'd40;
    localparam logic [SPEED_W-1:0] MAX_RST  = 8'd180;
    localparam logic [SPEED_W-1:0] STEP_RST = 8'd5;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_STOP   = 3'd0,
        CMD_ARM    = 3'd1,
        CMD_DOWN   = 3'd2,
        CMD_UP     = 3'd3,
        CMD_ADJUST = 3'd4,
        CMD_SET    = 3'd5
    } t_cmd;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ARM  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP = 3'd3;

    // Configuration register set.
    typedef struct packed {
        logic [SPEED_W-1:0] arm_speed;
        logic [SPEED_W-1:0] min_speed;
        logic [SPEED_W-1:0] max_speed;
        logic [SPEED_W-1:0] step_size;
    } t_cfg;

    // One decoded input item.
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [DELTA_W-1:0] delta;
        logic [SPEED_W-1:0]        target_speed;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [SPEED_W-1:0] speed_out;
        logic               running_out;
        logic               accepted;
    } t_result;

    // Widen an unsigned speed to the signed sum width.
    function automatic logic signed [SUM_W-1:0] to_sum(input logic [SPEED_W-1:0] v);
        to_sum = $signed({{(SUM_W-SPEED_W){1'b0}}, v});
    endfunction

    // A requested speed is valid if it is zero, arms a stopped motor,
    // launches an armed motor, or lies in the running range.
    function automatic logic speed_ok(
        input logic signed [SUM_W-1:0] s,
        input logic [SPEED_W-1:0]      cur,
        input logic                    running,
        input t_cfg                    cfg
    );
        logic signed [SUM_W-1:0] launch;
        logic is_zero;
        logic arming;
        logic launching;
        logic in_range;
        launch    = to_sum(cfg.arm_speed) + to_sum(cfg.step_size);
        is_zero   = (s == '0);
        arming    = (cur == '0) && (s == to_sum(cfg.arm_speed));
        launching = (cur == cfg.arm_speed) && (s == launch) &&
                    (launch <= to_sum(8'd255));
        in_range  = running && (s >= to_sum(cfg.min_speed)) &&
                    (s <= to_sum(cfg.max_speed));
        speed_ok  = is_zero || arming || launching || in_range;
    endfunction

endpackage

`default_nettype wire

// ===== sv/motor_throttle_arming_controller.sv =====
// ----------------------------------------------------------------------------
// Motor throttle arming controller
// Guards one motor's throttle: keeps speed and running flag, and applies
// stop, arm, step, adjust and set commands under the arming rules.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the command
// logic into the result register.
// Throughput: one item per cycle unless the result stream stalls; the speed
// register is updated with the result register, so the next item sees it at once.
// Reset (synchronous, active low): speed 0, stopped, registers at defaults,
// both pipeline stages empty.
`default_nettype none

module motor_throttle_arming_controller
    import mtac_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input item stream.
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [2:0] cmd, [11:3] delta, [19:12] target_speed, [23:20] zero
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Result item stream.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [7:0] speed_out, [8] running_out, [9] accepted, [15:10] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [IDX_W-1:0]      i_cfg_addr,
    input  wire logic [SPEED_W-1:0]    i_cfg_data
);

    t_cfg               cfg;
    t_result            result;
    logic               advance;
    logic               in_fire;

    logic               r_in_valid;
    t_item              r_item;
    logic               r_out_valid;
    t_result            r_result;
    logic [SPEED_W-1:0] r_speed;
    logic               r_running;

    mtac_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mtac_core u_core (
        .i_item    (r_item),
        .i_cfg     (cfg),
        .i_speed   (r_speed),
        .i_running (r_running),
        .o_result  (result)
    );

    // The pipeline moves whenever the result register is free or drained.
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.cmd          <= i_s_axis_tdata[2:0];
            r_item.delta        <= $signed(i_s_axis_tdata[11:3]);
            r_item.target_speed <= i_s_axis_tdata[19:12];
        end
    end

    // Motor state, updated as each item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_running <= 1'b0;
        end else if (r_in_valid && advance) begin
            r_speed   <= result.speed_out;
            r_running <= result.running_out;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_result <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_result.accepted, r_result.running_out,
                              r_result.speed_out};

endmodule

`default_nettype wire

// ===== sv/mtac_cfg.sv =====
// ----------------------------------------------------------------------------
// Motor throttle arming controller configuration registers
// Holds the arm, minimum, maximum and step values written over the
// plain write port. Writes to indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mtac_cfg
    import mtac_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_addr,
    input  wire logic [SPEED_W-1:0] i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ARM:  n_cfg.arm_speed = i_cfg_data;
                REG_MIN:  n_cfg.min_speed = i_cfg_data;
                REG_MAX:  n_cfg.max_speed = i_cfg_data;
                REG_STEP: n_cfg.step_size = i_cfg_data;
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_speed <= ARM_RST;
            r_cfg.min_speed <= MIN_RST;
            r_cfg.max_speed <= MAX_RST;
            r_cfg.step_size <= STEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/mtac_core.sv =====
// ----------------------------------------------------------------------------
// Motor throttle arming controller command logic
// Works out the next speed, running flag and accept bit for one command
// from the present state and the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module mtac_core
    import mtac_pkg::*;
(
    input  wire t_item              i_item,
    input  wire t_cfg               i_cfg,
    input  wire logic [SPEED_W-1:0] i_speed,
    input  wire logic               i_running,
    output t_result                 o_result
);

    logic signed [SUM_W-1:0] first_req;
    logic signed [SUM_W-1:0] clamp_req;
    logic                    has_clamp;
    logic                    run_eff;
    logic                    first_ok;
    logic                    clamp_ok;
    logic signed [SUM_W-1:0] cur_s;
    logic signed [SUM_W-1:0] delta_s;

    assign cur_s   = to_sum(i_speed);
    assign delta_s = SUM_W'(i_item.delta);

    // Pick the first request and the fallback clamp for the command.
    always_comb begin
        first_req = '0;
        clamp_req = '0;
        has_clamp = 1'b0;
        run_eff   = i_running;
        case (i_item.cmd)
            CMD_STOP: begin
                first_req = '0;
                run_eff   = 1'b0;
            end
            CMD_ARM: begin
                first_req = to_sum(i_cfg.arm_speed);
            end
            CMD_DOWN: begin
                first_req = cur_s - to_sum(i_cfg.step_size);
                clamp_req = to_sum(i_cfg.min_speed);
                has_clamp = 1'b1;
            end
            CMD_UP: begin
                // Stepping up from the arm speed launches at the minimum.
                if (i_speed == i_cfg.arm_speed) begin
                    first_req = to_sum(i_cfg.min_speed);
                    run_eff   = 1'b1;
                end else begin
                    first_req = cur_s + to_sum(i_cfg.step_size);
                end
                clamp_req = to_sum(i_cfg.max_speed);
                has_clamp = 1'b1;
            end
            CMD_ADJUST: begin
                first_req = cur_s + delta_s;
                clamp_req = (delta_s > 0) ? to_sum(i_cfg.max_speed)
                                          : to_sum(i_cfg.min_speed);
                has_clamp = 1'b1;
            end
            CMD_SET: begin
                first_req = to_sum(i_item.target_speed);
            end
            default: begin
                first_req = '0;
            end
        endcase
    end

    // Check both requests against the state seen by this command.
    assign first_ok = speed_ok(first_req, i_speed, run_eff, i_cfg) &&
                      (i_item.cmd <= CMD_SET);
    assign clamp_ok = has_clamp && speed_ok(clamp_req, i_speed, run_eff, i_cfg);

    // Select the new speed.
    always_comb begin
        o_result.running_out = run_eff;
        o_result.accepted    = first_ok;
        if (first_ok) begin
            o_result.speed_out = first_req[SPEED_W-1:0];
        end else if (clamp_ok) begin
            o_result.speed_out = clamp_req[SPEED_W-1:0];
        end else begin
            o_result.speed_out = i_speed;
        end
    end

endmodule

`default_nettype wire
